[sv/bdq_pkg.sv]
// ============================================================================
// bdq_pkg
// Shared widths, operation and status codes, and the storage cell control
// types of the bounded deque with search.
// ============================================================================
package bdq_pkg;

  // Default number of entries the store can hold.
  localparam int DEPTH_DEF = 16;

  // Field widths that the item formats fix.
  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes of an input item.
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd5;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // What a storage cell does.
  typedef enum logic [1:0] {
    CELL_HOLD,   // keep the stored word
    CELL_LEFT,   // take the word of the left neighbor (chain shifts away from the head)
    CELL_RIGHT,  // take the word of the right neighbor (chain shifts toward the head)
    CELL_LOAD    // take the broadcast word if this cell is the selected one
  } cell_op_t;

  // Control broadcast to every cell of one chain.
  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  data;
  } cell_ctl_t;

endpackage

[sv/bdq_req_if.sv]
// ============================================================================
// bdq_req_if
// Input item channel: valid/ready handshake with the operation and its value.
// ============================================================================
interface bdq_req_if;
  logic                                valid;
  logic                                ready;
  logic [bdq_pkg::FUNC_W-1:0]          func;
  logic signed [bdq_pkg::WORD_W-1:0]   value_in;

  modport source (output valid, func, value_in, input ready);
  modport sink   (input valid, func, value_in, output ready);
endinterface

[sv/bdq_rsp_if.sv]
// ============================================================================
// bdq_rsp_if
// Result item channel: valid/ready handshake with status, value, position
// and the last-result flag.
// ============================================================================
interface bdq_rsp_if #(
  parameter int POS_W = $clog2(bdq_pkg::DEPTH_DEF + 1)
);
  logic                                valid;
  logic                                ready;
  logic [bdq_pkg::STATUS_W-1:0]        status;
  logic signed [bdq_pkg::WORD_W-1:0]   value_out;
  logic [POS_W-1:0]                    position;
  logic                                last;

  modport source (output valid, status, value_out, position, last, input ready);
  modport sink   (input valid, status, value_out, position, last, output ready);
endinterface

[sv/bounded_deque_with_search.sv]
// ============================================================================
// bounded_deque_with_search
// Push and pop: one item per cycle unless the result channel stalls; the result
// is registered and shows in the cycle after accept. Search and dump rotate the
// front chain once around all DEPTH cells, one cell per cycle while the result
// register is free, and take no new item until done; one result per matching or
// stored entry, or not-found if none matches. An empty store answers at once.
// Reset clears the entry count, the controller and the result valid flag; the
// stored words are not cleared and are read only after being written.
// ============================================================================
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bdq_req_if.sink   req,
  bdq_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Controller states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]                        state, state_next;
  logic [CNT_W-1:0]                  count, count_next;
  logic [IDX_W-1:0]                  step, step_next;
  logic                              is_search, is_search_next;
  logic signed [bdq_pkg::WORD_W-1:0] key, key_next;
  logic                              pend_valid, pend_valid_next;
  logic [CNT_W-1:0]                  pend_pos, pend_pos_next;

  logic                              out_valid, out_valid_next;
  logic [bdq_pkg::STATUS_W-1:0]      out_status;
  logic signed [bdq_pkg::WORD_W-1:0] out_value;
  logic [CNT_W-1:0]                  out_pos;
  logic                              out_last;

  logic                              emit;
  logic [bdq_pkg::STATUS_W-1:0]      e_status;
  logic signed [bdq_pkg::WORD_W-1:0] e_value;
  logic [CNT_W-1:0]                  e_pos;
  logic                              e_last;

  bdq_pkg::cell_ctl_t                f_ctl, b_ctl;
  logic [IDX_W-1:0]                  sel;
  logic signed [bdq_pkg::WORD_W-1:0] f_head, b_head;

  logic                              out_free;
  logic                              accept;
  logic                              full;
  logic                              empty;
  logic                              in_range;
  logic [CNT_W-1:0]                  step_pos;

  // Front chain keeps the entries front to back; back chain keeps them back
  // to front. Each end is then the head of one chain.
  bdq_chain #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_front (
    .clk  (clk),
    .ctl  (f_ctl),
    .sel  (sel),
    .head (f_head)
  );

  bdq_chain #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_back (
    .clk  (clk),
    .ctl  (b_ctl),
    .sel  (sel),
    .head (b_head)
  );

  // Handshake: a new item or walk step only when the result register is free.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign sel      = count[IDX_W-1:0];
  assign step_pos = CNT_W'(step) + CNT_W'(1);
  assign in_range = (CNT_W'(step) < count);

  // Operation decode and walk control.
  always_comb begin
    state_next      = state;
    count_next      = count;
    step_next       = step;
    is_search_next  = is_search;
    key_next        = key;
    pend_valid_next = pend_valid;
    pend_pos_next   = pend_pos;
    f_ctl           = '{op: bdq_pkg::CELL_HOLD, data: req.value_in};
    b_ctl           = '{op: bdq_pkg::CELL_HOLD, data: req.value_in};
    emit            = 1'b0;
    e_status        = bdq_pkg::ST_OK;
    e_value         = '0;
    e_pos           = '0;
    e_last          = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.func)
            bdq_pkg::FN_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                e_status = bdq_pkg::ST_FULL;
              end else begin
                f_ctl.op   = bdq_pkg::CELL_LEFT;
                b_ctl.op   = bdq_pkg::CELL_LOAD;
                count_next = count + CNT_W'(1);
              end
            end
            bdq_pkg::FN_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                e_status = bdq_pkg::ST_FULL;
              end else begin
                b_ctl.op   = bdq_pkg::CELL_LEFT;
                f_ctl.op   = bdq_pkg::CELL_LOAD;
                count_next = count + CNT_W'(1);
              end
            end
            bdq_pkg::FN_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                e_status = bdq_pkg::ST_EMPTY;
              end else begin
                e_value    = f_head;
                f_ctl.op   = bdq_pkg::CELL_RIGHT;
                count_next = count - CNT_W'(1);
              end
            end
            bdq_pkg::FN_POP_BACK: begin
              emit = 1'b1;
              if (empty) begin
                e_status = bdq_pkg::ST_EMPTY;
              end else begin
                e_value    = b_head;
                b_ctl.op   = bdq_pkg::CELL_RIGHT;
                count_next = count - CNT_W'(1);
              end
            end
            bdq_pkg::FN_SEARCH: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = bdq_pkg::ST_NOTFOUND;
              end else begin
                state_next      = S_WALK;
                step_next       = '0;
                is_search_next  = 1'b1;
                key_next        = req.value_in;
                pend_valid_next = 1'b0;
              end
            end
            bdq_pkg::FN_DUMP: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = bdq_pkg::ST_EMPTY;
              end else begin
                state_next     = S_WALK;
                step_next      = '0;
                is_search_next = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Rotate the front chain one cell a cycle while out_free; head shows entry 'step'.
      S_WALK: begin
        if (out_free) begin
          f_ctl.op = bdq_pkg::CELL_RIGHT;
          if (in_range) begin
            if (is_search) begin
              // A match is held back until the next one shows it was not last.
              if (f_head == key) begin
                if (pend_valid) begin
                  emit   = 1'b1;
                  e_pos  = pend_pos;
                  e_last = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_pos_next   = step_pos;
              end
            end else begin
              emit    = 1'b1;
              e_value = f_head;
              e_pos   = step_pos;
              e_last  = (step_pos == count);
            end
          end
          if (step == IDX_W'(DEPTH - 1)) begin
            state_next = is_search ? S_FINISH : S_IDLE;
          end else begin
            step_next = step + IDX_W'(1);
          end
        end
      end

      // Release the held match as the final result, or report no match.
      S_FINISH: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            e_pos = pend_pos;
          end else begin
            e_status = bdq_pkg::ST_NOTFOUND;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase

    out_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      step       <= '0;
      is_search  <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      step       <= step_next;
      is_search  <= is_search_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key      <= key_next;
    pend_pos <= pend_pos_next;
    if (emit) begin
      out_status <= e_status;
      out_value  <= e_value;
      out_pos    <= e_pos;
      out_last   <= e_last;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.value_out = out_value;
  assign rsp.position  = out_pos;
  assign rsp.last      = out_last;

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // An accepted push on a store that is not full adds exactly one entry.
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full &&
     (req.func == bdq_pkg::FN_PUSH_FRONT || req.func == bdq_pkg::FN_PUSH_BACK))
    |=> count == $past(count) + CNT_W'(1))
    else $error("push did not add one entry");

  // No new item is taken while a search or dump is walking the store.
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !req.ready)
    else $error("item accepted during a walk");

  // A nonzero reported position always names a stored entry.
  a_pos_live: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pos != '0) |-> (out_pos <= count && out_status == bdq_pkg::ST_OK))
    else $error("result position outside the store");

endmodule

[sv/bdq_cell.sv]
// ============================================================================
// bdq_cell
// One storage cell of a chain: holds a word, takes a neighbor's word when the
// chain shifts, or the broadcast word when its own index is selected.
// ============================================================================
module bdq_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                               clk,
  input  bdq_pkg::cell_ctl_t                 ctl,
  input  logic [IDX_W-1:0]                   sel,
  input  logic signed [bdq_pkg::WORD_W-1:0]  left,
  input  logic signed [bdq_pkg::WORD_W-1:0]  right,
  output logic signed [bdq_pkg::WORD_W-1:0]  q
);

  // Stored word; payload only, so no reset.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      bdq_pkg::CELL_HOLD:  q <= q;
      bdq_pkg::CELL_LEFT:  q <= left;
      bdq_pkg::CELL_RIGHT: q <= right;
      bdq_pkg::CELL_LOAD: begin
        if (sel == IDX_W'(IDX)) begin
          q <= ctl.data;
        end
      end
      default: q <= q;
    endcase
  end

endmodule

[sv/bdq_chain.sv]
// ============================================================================
// bdq_chain
// A row of DEPTH storage cells with the head at cell 0. The broadcast word
// enters at the head on a shift away from it, and the head word wraps into
// the far end on a shift toward it, so the row can also rotate.
// ============================================================================
module bdq_chain #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  bdq_pkg::cell_ctl_t                 ctl,
  input  logic [IDX_W-1:0]                   sel,
  output logic signed [bdq_pkg::WORD_W-1:0]  head
);

  logic signed [bdq_pkg::WORD_W-1:0] q [DEPTH];

  // Neighbor wiring: cell 0 takes the broadcast word from the left and the
  // last cell takes the head word from the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [bdq_pkg::WORD_W-1:0] left_w;
    logic signed [bdq_pkg::WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = ctl.data;
    end else begin : g_inner_left
      assign left_w = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_w = q[0];
    end else begin : g_inner_right
      assign right_w = q[i+1];
    end

    bdq_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .sel   (sel),
      .left  (left_w),
      .right (right_w),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule
